[hdl/cvm_pkg.sv]
// ----------------------------------------------------------------------------
// cvm_pkg
// shared types, constants and arithmetic helpers of the view matrix builder
// ----------------------------------------------------------------------------
package cvm_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// kind decode: only the two bits are looked at
	localparam int KIND_BIT_TARGET = 0;
	localparam int KIND_BIT_EULER  = 1;

	// angle reduction and cordic constants, q30
	localparam int          CQ              = 30;
	localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
	localparam logic [31:0] HALF_PI_HALF    = 32'd843314856;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam int          ATAN_ENTRIES    = 24;

	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314857, 32'd497837829, 32'd263043836, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
		logic [31:0] up_x;
		logic [31:0] up_y;
		logic [31:0] up_z;
	} pose_t;

	typedef struct packed {
		logic [31:0] right_x;
		logic [31:0] right_y;
		logic [31:0] right_z;
		logic [31:0] down_x;
		logic [31:0] down_y;
		logic [31:0] down_z;
		logic [31:0] fwd_x;
		logic [31:0] fwd_y;
		logic [31:0] fwd_z;
		logic [31:0] shift_u;
		logic [31:0] shift_v;
		logic [31:0] shift_w;
	} view_t;

	// stages of the normalize pipeline
	function automatic int norm_lat(input int frac);
		return frac + 39;
	endfunction

	// stages of the sine/cosine pipeline: five reduction stages, cordic, output
	function automatic int sincos_lat(input int steps);
		return ((steps < ATAN_ENTRIES) ? steps : ATAN_ENTRIES) + 6;
	endfunction

	// round half up, then drop sh bits
	function automatic logic signed [65:0] rnd_q(input logic signed [65:0] p, input int sh);
		logic signed [65:0] half;
		half = 66'sd1 <<< (sh - 1);
		return (p + half) >>> sh;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		r = v[31:0];
		if (v > 66'sd2147483647) begin
			r = 32'h7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'h80000000;
		end
		return r;
	endfunction

endpackage

[hdl/cvm_if.sv]
// ----------------------------------------------------------------------------
// cvm_pose_if / cvm_view_if
// valid/ready channels carrying one pose item and one view item
// ----------------------------------------------------------------------------
interface cvm_pose_if;
	import cvm_pkg::*;
	logic  valid;
	logic  ready;
	pose_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cvm_view_if;
	import cvm_pkg::*;
	logic  valid;
	logic  ready;
	view_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/cvm_delay.sv]
// ----------------------------------------------------------------------------
// cvm_delay
// enabled shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module cvm_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];
endmodule

[hdl/cvm_norm.sv]
// ----------------------------------------------------------------------------
// cvm_norm
// pipelined vector normalize: scale, square sum, bit-serial sqrt, divide
// ----------------------------------------------------------------------------
module cvm_norm #(
	parameter int IN_W      = 34,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [2:0][IN_W-1:0]      vec,
	output logic [2:0][FRAC_BITS+1:0] unit
);
	localparam int OW       = FRAC_BITS + 2;
	localparam int PW       = $clog2(IN_W);
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = FRAC_BITS + 1;
	localparam logic [PW-1:0] LEAD = PW'(30);

	typedef struct packed {
		logic [63:0]      rad;
		logic [34:0]      rem;
		logic [31:0]      root;
		logic [2:0][30:0] mg;
		logic [2:0]       neg;
		logic             zero;
	} nsq_t;

	typedef struct packed {
		logic [2:0][32:0]        rem;
		logic [2:0][FRAC_BITS:0] quo;
		logic [31:0]             len;
		logic [2:0]              neg;
		logic                    zero;
	} ndv_t;

	// magnitudes and largest one
	logic [2:0][IN_W-1:0] mag_c, mag_s1, mag_s2;
	logic [2:0]           neg_c, neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [IN_W-1:0]      max_c, max_s1;
	logic [PW-1:0]        lead_c, lead_s2;
	logic                 zero_s2, zero_s3, zero_s4, zero_s5;
	logic [2:0][30:0]     mg_c, mg_s3, mg_s4, mg_s5;
	logic [2:0][61:0]     sq_s4;
	logic [63:0]          sum_s5;
	logic [2:0][OW-1:0]   unit_q;

	always_comb begin
		max_c = '0;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = vec[i][IN_W-1];
			mag_c[i] = neg_c[i] ? (~vec[i] + 1'b1) : vec[i];
			if (mag_c[i] > max_c) begin
				max_c = mag_c[i];
			end
		end
	end

	always_comb begin
		lead_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (max_s1[b]) begin
				lead_c = PW'(b);
			end
		end
	end

	// move the leading one of the largest magnitude to bit 30
	always_comb begin
		logic [IN_W+30:0] wide;
		logic [IN_W+30:0] sh;
		for (int i = 0; i < 3; i++) begin
			wide = {31'b0, mag_s2[i]};
			if (lead_s2 >= LEAD) begin
				sh = wide >> (lead_s2 - LEAD);
			end else begin
				sh = wide << (LEAD - lead_s2);
			end
			mg_c[i] = sh[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			neg_s1  <= neg_c;
			max_s1  <= max_c;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			lead_s2 <= lead_c;
			zero_s2 <= (max_s1 == '0);
			mg_s3   <= mg_c;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= mg_s3[i] * mg_s3[i];
			end
			mg_s4   <= mg_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			sum_s5  <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			mg_s5   <= mg_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	// integer square root, one root bit per stage
	nsq_t sqrt_s [SQ_STEPS];
	nsq_t sq_first;

	always_comb begin
		sq_first      = '0;
		sq_first.rad  = sum_s5;
		sq_first.mg   = mg_s5;
		sq_first.neg  = neg_s5;
		sq_first.zero = zero_s5;
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		nsq_t cur;
		nsq_t nxt;
		if (j == 0) begin : g_first
			assign cur = sq_first;
		end else begin : g_next
			assign cur = sqrt_s[j-1];
		end
		always_comb begin
			logic [34:0] rem2;
			logic [34:0] trial;
			logic        ge;
			nxt   = cur;
			rem2  = {cur.rem[32:0], cur.rad[63:62]};
			trial = {1'b0, cur.root, 2'b01};
			ge    = (rem2 >= trial);
			nxt.rem  = ge ? (rem2 - trial) : rem2;
			nxt.root = {cur.root[30:0], ge};
			nxt.rad  = {cur.rad[61:0], 2'b00};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[j] <= nxt;
			end
		end
	end

	// restoring divide of magnitude by length, one quotient bit per stage
	ndv_t div_s [DV_STEPS];
	ndv_t dv_first;

	always_comb begin
		dv_first      = '0;
		dv_first.len  = sqrt_s[SQ_STEPS-1].root;
		dv_first.neg  = sqrt_s[SQ_STEPS-1].neg;
		dv_first.zero = sqrt_s[SQ_STEPS-1].zero;
		for (int i = 0; i < 3; i++) begin
			dv_first.rem[i] = {2'b00, sqrt_s[SQ_STEPS-1].mg[i]};
		end
	end

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
		ndv_t cur;
		ndv_t nxt;
		if (j == 0) begin : g_first
			assign cur = dv_first;
		end else begin : g_next
			assign cur = div_s[j-1];
		end
		always_comb begin
			logic [32:0] r;
			logic        ge;
			nxt = cur;
			for (int i = 0; i < 3; i++) begin
				if (j == 0) begin
					r = cur.rem[i];
				end else begin
					r = {cur.rem[i][31:0], 1'b0};
				end
				ge = (r >= {1'b0, cur.len});
				nxt.rem[i] = ge ? (r - {1'b0, cur.len}) : r;
				nxt.quo[i] = {cur.quo[i][FRAC_BITS-1:0], ge};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= nxt;
			end
		end
	end

	// sign back, zero vector gives zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (div_s[DV_STEPS-1].zero) begin
					unit_q[i] <= '0;
				end else if (div_s[DV_STEPS-1].neg[i]) begin
					unit_q[i] <= -{1'b0, div_s[DV_STEPS-1].quo[i]};
				end else begin
					unit_q[i] <= {1'b0, div_s[DV_STEPS-1].quo[i]};
				end
			end
		end
	end

	assign unit = unit_q;
endmodule

[hdl/cvm_sincos.sv]
// ----------------------------------------------------------------------------
// cvm_sincos
// pipelined quadrant reduction and rotation-mode cordic for one angle
// ----------------------------------------------------------------------------
module cvm_sincos #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] ang,
	output logic [31:0] sine,
	output logic [31:0] cosine
);
	import cvm_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int UP    = CQ - FRAC_BITS;
	localparam int RS    = 61;
	localparam int SH    = RS - UP;
	localparam logic signed [31:0] RECIP = 32'((64'd1 << RS) / 64'(HALF_PI_Q30));
	localparam logic signed [63:0] KRND  = 64'sd1 <<< (SH - 1);
	localparam logic signed [31:0] HP_S  = HALF_PI_Q30;
	localparam logic signed [57:0] HP_W  = 58'(HALF_PI_Q30);

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [33:0] z;
		logic [1:0]         quad;
	} scr_t;

	// angle in q30, shifted by half a quadrant
	logic signed [57:0] n_c;
	logic signed [57:0] n_s1, n_s2, n_s3;
	logic signed [63:0] prod_s1;
	logic signed [24:0] k_s2;
	logic signed [57:0] kp_s3, r_s4;
	logic [1:0]         quad_s3, quad_s4, quad_c, quad_s5;
	logic signed [57:0] r_c;
	logic [30:0]        rem_s5;

	assign n_c = (58'($signed(ang)) <<< UP) + 58'(HALF_PI_HALF);

	// quadrant count by reciprocal multiply, off by at most one
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= n_c;
			prod_s1 <= $signed(ang) * RECIP;
			n_s2    <= n_s1;
			k_s2    <= 25'((prod_s1 + KRND) >>> SH);
			n_s3    <= n_s2;
			kp_s3   <= k_s2 * HP_S;
			quad_s3 <= k_s2[1:0];
			r_s4    <= n_s3 - kp_s3;
			quad_s4 <= quad_s3;
		end
	end

	// one step of correction brings the remainder into [0, pi/2)
	always_comb begin
		if (r_s4[57]) begin
			r_c    = r_s4 + HP_W;
			quad_c = quad_s4 - 2'd1;
		end else if (r_s4 >= HP_W) begin
			r_c    = r_s4 - HP_W;
			quad_c = quad_s4 + 2'd1;
		end else begin
			r_c    = r_s4;
			quad_c = quad_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5  <= r_c[30:0];
			quad_s5 <= quad_c;
		end
	end

	scr_t cr_first;
	always_comb begin
		cr_first.x    = 33'(CORDIC_GAIN_Q30);
		cr_first.y    = '0;
		cr_first.z    = $signed({3'b000, rem_s5}) - 34'(HALF_PI_HALF);
		cr_first.quad = quad_s5;
	end

	// one cordic rotation per stage
	scr_t cr_s [STEPS];
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam logic signed [33:0] AT = 34'(ATAN_Q30[i]);
		scr_t cur;
		scr_t nxt;
		if (i == 0) begin : g_first
			assign cur = cr_first;
		end else begin : g_next
			assign cur = cr_s[i-1];
		end
		always_comb begin
			logic signed [32:0] dx;
			logic signed [32:0] dy;
			dx = cur.y >>> i;
			dy = cur.x >>> i;
			nxt.quad = cur.quad;
			if (!cur.z[33]) begin
				nxt.x = cur.x - dx;
				nxt.y = cur.y + dy;
				nxt.z = cur.z - AT;
			end else begin
				nxt.x = cur.x + dx;
				nxt.y = cur.y - dy;
				nxt.z = cur.z + AT;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cr_s[i] <= nxt;
			end
		end
	end

	// quadrant fix-up and rounding back to the output format
	logic signed [33:0] cv_c, sv_c;
	logic [31:0]        sin_q, cos_q;

	always_comb begin
		logic signed [33:0] x;
		logic signed [33:0] y;
		x = 34'(cr_s[STEPS-1].x);
		y = 34'(cr_s[STEPS-1].y);
		unique case (cr_s[STEPS-1].quad)
			2'd0: begin
				cv_c = x;
				sv_c = y;
			end
			2'd1: begin
				cv_c = -y;
				sv_c = x;
			end
			2'd2: begin
				cv_c = -x;
				sv_c = -y;
			end
			default: begin
				cv_c = y;
				sv_c = -x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= sat32(rnd_q(66'(cv_c), UP));
			sin_q <= sat32(rnd_q(66'(sv_c), UP));
		end
	end

	assign sine   = sin_q;
	assign cosine = cos_q;
endmodule

[hdl/camera_view_matrix_builder_top.sv]
// ----------------------------------------------------------------------------
// camera_view_matrix_builder_top
// builds view matrix rows and translation from a camera pose
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | item
//  pose    | in  | valid / ready | kind, position, direction/target/angles, up
//  view    | out | valid / ready | u, v, w rows and -dot(axis, position)
//
// one pose enters per cycle while the output is not stalled; the pipeline depth
// is set by two normalize pipelines in series: 32 sqrt stages and
// FRAC_BITS+1 divide stages each
// the euler path (reduction, cordic, products) runs beside and is delayed
// to match; a kind is chosen just before the translation products
// reset clears only the valid bits; a stall at the output holds every stage
// while the last one is full, and an empty last stage lets the pipe advance
// ----------------------------------------------------------------------------
module camera_view_matrix_builder_top #(
	parameter int FRAC_BITS    = cvm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = cvm_pkg::CORDIC_STEPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cvm_pose_if.sink   pose,
	cvm_view_if.source view
);
	import cvm_pkg::*;

	localparam int OW  = FRAC_BITS + 2;
	localparam int LN  = norm_lat(FRAC_BITS);
	localparam int LC  = sincos_lat(CORDIC_STEPS);
	localparam int LA  = 2 * LN + 4;  // look-at axes, counted from the input stage
	localparam int LE  = LC + 3;      // euler axes
	localparam int DE  = LA - LE;
	localparam int LAT = LA + 3;

	// ---------------- flow control ----------------
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en         = !vld_q[LAT-1] || view.ready;
	assign pose.ready = en;
	assign view.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pose.valid};
		end
	end

	// ---------------- input stage ----------------
	logic [2:0][31:0] pos_c, vec_c, up_c;
	logic [1:0]       kind_s1;
	logic [2:0][31:0] pos_s1, vec_s1, up_s1;
	logic [2:0][33:0] dir_s1;

	assign pos_c = {pose.data.pos_z, pose.data.pos_y, pose.data.pos_x};
	assign vec_c = {pose.data.vec_z, pose.data.vec_y, pose.data.vec_x};
	assign up_c  = {pose.data.up_z, pose.data.up_y, pose.data.up_x};

	// target mode looks along target minus position
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= pose.data.kind;
			pos_s1  <= pos_c;
			vec_s1  <= vec_c;
			up_s1   <= up_c;
			for (int i = 0; i < 3; i++) begin
				if (pose.data.kind[KIND_BIT_TARGET]) begin
					dir_s1[i] <= 34'($signed(vec_c[i])) - 34'($signed(pos_c[i]));
				end else begin
					dir_s1[i] <= 34'($signed(vec_c[i]));
				end
			end
		end
	end

	// ---------------- look-at path ----------------
	logic [2:0][OW-1:0] w_n, u_n, w_d1, w_d2, u_d;
	logic [2:0][31:0]   up_d;

	cvm_norm #(.IN_W(34), .FRAC_BITS(FRAC_BITS)) u_norm_fwd (
		.clk  (clk),
		.en   (en),
		.vec  (dir_s1),
		.unit (w_n)
	);

	cvm_delay #(.W(96), .DEPTH(LN)) u_dly_up (
		.clk (clk),
		.en  (en),
		.d   (up_s1),
		.q   (up_d)
	);

	// right axis before normalize: cross(w, up), kept wide
	logic signed [OW+31:0] cpa1_s1 [3];
	logic signed [OW+31:0] cpb1_s1 [3];
	logic [2:0][34:0]      cr1_s2;

	for (genvar i = 0; i < 3; i++) begin : g_cross_up
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				cpa1_s1[i] <= $signed(w_n[J]) * $signed(up_d[K]);
				cpb1_s1[i] <= $signed(w_n[K]) * $signed(up_d[J]);
				cr1_s2[i]  <= 35'(rnd_q(66'(cpa1_s1[i]), FRAC_BITS)
					- rnd_q(66'(cpb1_s1[i]), FRAC_BITS));
			end
		end
	end

	cvm_norm #(.IN_W(35), .FRAC_BITS(FRAC_BITS)) u_norm_right (
		.clk  (clk),
		.en   (en),
		.vec  (cr1_s2),
		.unit (u_n)
	);

	cvm_delay #(.W(3 * OW), .DEPTH(LN + 2)) u_dly_fwd1 (
		.clk (clk),
		.en  (en),
		.d   (w_n),
		.q   (w_d1)
	);

	cvm_delay #(.W(3 * OW), .DEPTH(2)) u_dly_fwd2 (
		.clk (clk),
		.en  (en),
		.d   (w_d1),
		.q   (w_d2)
	);

	cvm_delay #(.W(3 * OW), .DEPTH(2)) u_dly_right (
		.clk (clk),
		.en  (en),
		.d   (u_n),
		.q   (u_d)
	);

	// down axis: cross(w, u), saturated
	logic signed [2*OW-1:0] cpa2_s1 [3];
	logic signed [2*OW-1:0] cpb2_s1 [3];
	logic [2:0][31:0]       v_s2;

	for (genvar i = 0; i < 3; i++) begin : g_cross_right
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				cpa2_s1[i] <= $signed(w_d1[J]) * $signed(u_n[K]);
				cpb2_s1[i] <= $signed(w_d1[K]) * $signed(u_n[J]);
				v_s2[i]    <= sat32(rnd_q(66'(cpa2_s1[i]), FRAC_BITS)
					- rnd_q(66'(cpb2_s1[i]), FRAC_BITS));
			end
		end
	end

	// ---------------- euler path ----------------
	logic [2:0][31:0] sn, cs;

	for (genvar i = 0; i < 3; i++) begin : g_trig
		cvm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
			.clk    (clk),
			.en     (en),
			.ang    (vec_s1[i]),
			.sine   (sn[i]),
			.cosine (cs[i])
		);
	end

	// rounded product; sines and cosines stay within a few lsb of unit
	// magnitude, so every euler product fits 32 bits
	function automatic logic [31:0] mul_r(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		logic signed [65:0] r;
		p = $signed(a) * $signed(b);
		r = rnd_q(66'(p), FRAC_BITS);
		return r[31:0];
	endfunction

	function automatic logic [31:0] add_s(input logic [31:0] a, input logic [31:0] b);
		return sat32(66'($signed(a)) + 66'($signed(b)));
	endfunction

	function automatic logic [31:0] sub_s(input logic [31:0] a, input logic [31:0] b);
		return sat32(66'($signed(a)) - 66'($signed(b)));
	endfunction

	logic [31:0] sysx_s1, cysx_s1, cycz_s1, cxsz_s1, czsy_s1, cysz_s1;
	logic [31:0] cxcz_s1, sysz_s1, cxsy_s1, cycx_s1, sx_s1, sz_s1, cz_s1;
	logic [31:0] cycz_s2, cxsz_s2, czsy_s2, cysz_s2, cxcz_s2, sysz_s2;
	logic [31:0] cxsy_s2, cycx_s2, sx_s2;
	logic [31:0] t1_s2, t2_s2, t3_s2, t4_s2;
	logic [8:0][31:0] eu_s3, eu_d;

	always_ff @(posedge clk) begin
		if (en) begin
			sysx_s1 <= mul_r(sn[1], sn[0]);
			cysx_s1 <= mul_r(cs[1], sn[0]);
			cycz_s1 <= mul_r(cs[1], cs[2]);
			cxsz_s1 <= mul_r(cs[0], sn[2]);
			czsy_s1 <= mul_r(cs[2], sn[1]);
			cysz_s1 <= mul_r(cs[1], sn[2]);
			cxcz_s1 <= mul_r(cs[0], cs[2]);
			sysz_s1 <= mul_r(sn[1], sn[2]);
			cxsy_s1 <= mul_r(cs[0], sn[1]);
			cycx_s1 <= mul_r(cs[1], cs[0]);
			sx_s1   <= sn[0];
			sz_s1   <= sn[2];
			cz_s1   <= cs[2];

			t1_s2   <= mul_r(sysx_s1, sz_s1);
			t2_s2   <= mul_r(sysx_s1, cz_s1);
			t3_s2   <= mul_r(cysx_s1, sz_s1);
			t4_s2   <= mul_r(cysx_s1, cz_s1);
			cycz_s2 <= cycz_s1;
			cxsz_s2 <= cxsz_s1;
			czsy_s2 <= czsy_s1;
			cysz_s2 <= cysz_s1;
			cxcz_s2 <= cxcz_s1;
			sysz_s2 <= sysz_s1;
			cxsy_s2 <= cxsy_s1;
			cycx_s2 <= cycx_s1;
			sx_s2   <= sx_s1;

			eu_s3[0] <= add_s(cycz_s2, t1_s2);
			eu_s3[1] <= cxsz_s2;
			eu_s3[2] <= sub_s(t3_s2, czsy_s2);
			eu_s3[3] <= sub_s(t2_s2, cysz_s2);   // corrected sy*sx*cz - cy*sz
			eu_s3[4] <= cxcz_s2;
			eu_s3[5] <= add_s(t4_s2, sysz_s2);
			eu_s3[6] <= cxsy_s2;
			eu_s3[7] <= sub_s(32'd0, sx_s2);
			eu_s3[8] <= cycx_s2;
		end
	end

	cvm_delay #(.W(288), .DEPTH(DE)) u_dly_euler (
		.clk (clk),
		.en  (en),
		.d   (eu_s3),
		.q   (eu_d)
	);

	// ---------------- kind select and translation ----------------
	logic [1:0]       kind_d;
	logic [2:0][31:0] pos_d;

	cvm_delay #(.W(2), .DEPTH(LA)) u_dly_kind (
		.clk (clk),
		.en  (en),
		.d   (kind_s1),
		.q   (kind_d)
	);

	cvm_delay #(.W(96), .DEPTH(LA)) u_dly_pos (
		.clk (clk),
		.en  (en),
		.d   (pos_s1),
		.q   (pos_d)
	);

	logic [8:0][31:0]   la_ax, ax_c, ax_s1;
	logic signed [63:0] dp_s1 [9];
	view_t              res_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			la_ax[i]     = 32'($signed(u_d[i]));
			la_ax[3 + i] = v_s2[i];
			la_ax[6 + i] = 32'($signed(w_d2[i]));
		end
		ax_c = kind_d[KIND_BIT_EULER] ? eu_d : la_ax;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax_c;
			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s1[3 * r + i] <= $signed(ax_c[3 * r + i]) * $signed(pos_d[i]);
				end
			end
		end
	end

	function automatic logic [31:0] shift_of(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic signed [63:0] c);
		logic signed [65:0] s;
		s = rnd_q(66'(a), FRAC_BITS) + rnd_q(66'(b), FRAC_BITS) + rnd_q(66'(c), FRAC_BITS);
		return sat32(-s);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.right_x <= ax_s1[0];
			res_s2.right_y <= ax_s1[1];
			res_s2.right_z <= ax_s1[2];
			res_s2.down_x  <= ax_s1[3];
			res_s2.down_y  <= ax_s1[4];
			res_s2.down_z  <= ax_s1[5];
			res_s2.fwd_x   <= ax_s1[6];
			res_s2.fwd_y   <= ax_s1[7];
			res_s2.fwd_z   <= ax_s1[8];
			res_s2.shift_u <= shift_of(dp_s1[0], dp_s1[1], dp_s1[2]);
			res_s2.shift_v <= shift_of(dp_s1[3], dp_s1[4], dp_s1[5]);
			res_s2.shift_w <= shift_of(dp_s1[6], dp_s1[7], dp_s1[8]);
		end
	end

	assign view.data = res_s2;
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the view matrix builder: a table of directed poses,
// then random poses of every kind, each checked field by field against a
// fixed-point view matrix calculator kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
	import cvm_pkg::*;

	localparam int FB         = FRAC_BITS_DEF;
	localparam int STEPS      = CORDIC_STEPS_DEF;
	localparam int LATENCY    = 2 * (FB + 39) + 7;
	localparam int N_RANDOM   = 2000;
	localparam int STALL_MAX  = 4000;
	localparam logic [1:0] K_DIR    = 2'd0;
	localparam logic [1:0] K_TARGET = 2'd1;
	localparam logic [1:0] K_EULER  = 2'd2;
	localparam logic [1:0] K_EULER3 = 2'd3;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;

	logic clk;
	logic arst_n;

	cvm_pose_if pose ();
	cvm_view_if view ();

	camera_view_matrix_builder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose.sink),
		.view   (view.source)
	);

	// matrices still owed by the block, oldest first
	view_t pending_views[$];
	int    errors;
	int    stall_cycles;
	bit    no_idle;
	bit    sending;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// fixed-point view matrix calculator
	// ---------------------------------------------------------------------

	function automatic longint rmul(input longint a, input longint b);
		return (a * b + (longint'(1) <<< (FB - 1))) >>> FB;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// zero vectors stay zero; others are scaled into [2^30, 2^31) first
	function automatic void unit_vec(input longint a[3], output longint r[3]);
		longint unsigned mg[3];
		longint unsigned m;
		longint unsigned sum;
		longint unsigned len;
		bit neg[3];
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = a[i] < 0;
			mg[i] = neg[i] ? longint'(-a[i]) : a[i];
			if (mg[i] > m) m = mg[i];
		end
		if (m == 0) begin
			r = '{0, 0, 0};
			return;
		end
		while (m >= (64'd1 << 31)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
		end
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
		end
		for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			r[i] = longint'((mg[i] << FB) / len);
			if (neg[i]) r[i] = -r[i];
		end
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
		r[0] = rmul(a[1], b[2]) - rmul(a[2], b[1]);
		r[1] = rmul(a[2], b[0]) - rmul(a[0], b[2]);
		r[2] = rmul(a[0], b[1]) - rmul(a[1], b[0]);
	endfunction

	// quadrant reduction, then rotation-mode cordic in q30
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint aq, n, k, x, y, z, t, dx, dy, hp;
		hp = longint'(HALF_PI_Q30);
		aq = ang * (longint'(1) <<< (CQ - FB));
		n = aq + hp / 2;
		k = n / hp;
		if (n % hp != 0 && n < 0) k--;
		z = aq - k * hp;
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				t = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_Q30[i]);
			end else begin
				t = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_Q30[i]);
			end
			x = t;
		end
		case (k & 3)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		c = clip32((c + (longint'(1) <<< (CQ - FB - 1))) >>> (CQ - FB));
		s = clip32((s + (longint'(1) <<< (CQ - FB - 1))) >>> (CQ - FB));
	endfunction

	function automatic view_t view_of_pose(input pose_t p);
		longint ps[3], vc[3], up[3], u[3], v[3], w[3], tmp[3];
		longint sx, cx, sy, cy, sz, cz, sysx, cysx;
		longint sh[3];
		view_t r;
		ps = '{longint'(signed'(p.pos_x)), longint'(signed'(p.pos_y)),
			longint'(signed'(p.pos_z))};
		vc = '{longint'(signed'(p.vec_x)), longint'(signed'(p.vec_y)),
			longint'(signed'(p.vec_z))};
		up = '{longint'(signed'(p.up_x)), longint'(signed'(p.up_y)),
			longint'(signed'(p.up_z))};
		if (p.kind[KIND_BIT_EULER]) begin
			sin_cos(vc[0], sx, cx);
			sin_cos(vc[1], sy, cy);
			sin_cos(vc[2], sz, cz);
			sysx = rmul(sy, sx);
			cysx = rmul(cy, sx);
			u[0] = clip32(rmul(cy, cz) + rmul(sysx, sz));
			u[1] = clip32(rmul(cx, sz));
			u[2] = clip32(rmul(cysx, sz) - rmul(cz, sy));
			v[0] = clip32(rmul(sysx, cz) - rmul(cy, sz));
			v[1] = clip32(rmul(cx, cz));
			v[2] = clip32(rmul(cysx, cz) + rmul(sy, sz));
			w[0] = clip32(rmul(cx, sy));
			w[1] = clip32(-sx);
			w[2] = clip32(rmul(cy, cx));
		end else begin
			for (int i = 0; i < 3; i++)
				tmp[i] = p.kind[KIND_BIT_TARGET] ? vc[i] - ps[i] : vc[i];
			unit_vec(tmp, w);
			cross3(w, up, tmp);
			unit_vec(tmp, u);
			cross3(w, u, v);
			for (int i = 0; i < 3; i++) v[i] = clip32(v[i]);
		end
		for (int i = 0; i < 3; i++) sh[i] = 0;
		for (int i = 0; i < 3; i++) begin
			sh[0] += rmul(u[i], ps[i]);
			sh[1] += rmul(v[i], ps[i]);
			sh[2] += rmul(w[i], ps[i]);
		end
		r.right_x = u[0][31:0];
		r.right_y = u[1][31:0];
		r.right_z = u[2][31:0];
		r.down_x  = v[0][31:0];
		r.down_y  = v[1][31:0];
		r.down_z  = v[2][31:0];
		r.fwd_x   = w[0][31:0];
		r.fwd_y   = w[1][31:0];
		r.fwd_z   = w[2][31:0];
		r.shift_u = 32'(clip32(-sh[0]));
		r.shift_v = 32'(clip32(-sh[1]));
		r.shift_w = 32'(clip32(-sh[2]));
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// directed table
	// ---------------------------------------------------------------------

	typedef struct {
		pose_t p;
		bit    typed; // expected matrix typed in below
		view_t want;
	} pose_row_t;

	pose_row_t rows[$];

	function automatic pose_t mk(input logic [1:0] k,
		input logic [31:0] px, py, pz, vx, vy, vz, ux, uy, uz);
		pose_t p;
		p = '{k, px, py, pz, vx, vy, vz, ux, uy, uz};
		return p;
	endfunction

	task automatic add_row(input pose_t p, input bit typed, input view_t want);
		pose_row_t r;
		r.p = p;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 20 * ONE)) - 10 * ONE);
			2: return 32'($signed($urandom_range(0, 800 * ONE)) - 400 * ONE);
			default: return 32'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
		endcase
	endfunction

	function automatic pose_t rnd_pose();
		pose_t p;
		p.kind = 2'($urandom_range(0, 3));
		p.pos_x = rnd_word();
		p.pos_y = rnd_word();
		p.pos_z = rnd_word();
		p.vec_x = rnd_word();
		p.vec_y = rnd_word();
		p.vec_z = rnd_word();
		p.up_x = rnd_word();
		p.up_y = rnd_word();
		p.up_z = rnd_word();
		// now and then a degenerate vector: zero, target at the camera, or up along the view
		case ($urandom_range(0, 19))
			0: begin p.vec_x = '0; p.vec_y = '0; p.vec_z = '0; end
			1: begin p.up_x = p.vec_x; p.up_y = p.vec_y; p.up_z = p.vec_z; end
			2: begin p.vec_x = p.pos_x; p.vec_y = p.pos_y; p.vec_z = p.pos_z; end
			default: ;
		endcase
		return p;
	endfunction

	// ---------------------------------------------------------------------
	// checking: every accepted pose queues its matrix, every view pops one
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		view_t want;
		logic [31:0] got_f;
		logic [31:0] want_f;
		if (arst_n && pose.valid && pose.ready)
			pending_views.push_back(view_of_pose(pose.data));
		if (arst_n && view.valid && view.ready) begin
			if (pending_views.size() == 0) begin
				errors++;
				if (errors <= 10) $display("view item with nothing pending: %h", view.data);
			end else begin
				want = pending_views.pop_front();
				for (int i = 0; i < 12; i++) begin
					got_f = view.data[383 - 32 * i -: 32];
					want_f = want[383 - 32 * i -: 32];
					if (got_f !== want_f) begin
						errors++;
						if (errors <= 10)
							$display("field %0d mismatch: expected %h got %h", i, want_f,
								got_f);
					end
				end
			end
		end
	end

	// watchdog: cycles in which neither channel moves an item
	always @(posedge clk) begin
		if ((pose.valid && pose.ready) || (view.valid && view.ready))
			stall_cycles <= 0;
		else if (sending || pending_views.size() != 0)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("** camera_view_matrix_builder_top: FAILED **");
			$finish;
		end
	end

	// receiver: stalls about one cycle in ten, except in the quiet stretch
	always @(negedge clk) begin
		if (!arst_n)
			view.ready <= 1'b0;
		else
			view.ready <= no_idle || ($urandom_range(0, 99) >= 10);
	end

	// drive one pose, with a random gap ahead of it, and hold until taken
	task automatic send_pose(input pose_t p);
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			pose.valid <= 1'b0;
			@(negedge clk);
		end
		pose.valid <= 1'b1;
		pose.data <= p;
		@(posedge clk);
		while (!pose.ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		view_t zero_view;
		pose_t p;
		errors = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		sending = 1'b0;
		zero_view = '0;
		pose.valid = 1'b0;
		pose.data = '0;
		view.ready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// zero direction and target at the camera give an all-zero matrix
		add_row(mk(K_DIR, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0), 1, zero_view);
		add_row(mk(K_TARGET, 5 * ONE, -7 * ONE, ONE, 5 * ONE, -7 * ONE, ONE, 0, ONE, 0),
			1, zero_view);
		add_row(mk(K_TARGET, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
			1, zero_view);
		// plain look along z, up along the view, up of zero
		add_row(mk(K_DIR, 0, 0, 0, 0, 0, MAXV, 0, MAXV, 0), 0, zero_view);
		add_row(mk(K_DIR, ONE, ONE, ONE, 0, 0, ONE, 0, ONE, 0), 0, zero_view);
		add_row(mk(K_DIR, 3 * ONE, 0, -ONE, 0, 0, 2 * ONE, 0, 0, ONE), 0, zero_view);
		add_row(mk(K_DIR, ONE, 0, 0, ONE, ONE, 0, 0, 0, 0), 0, zero_view);
		// field extremes, and a 33-bit target difference
		add_row(mk(K_DIR, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0,
			zero_view);
		add_row(mk(K_DIR, MINV, MAXV, MINV, MINV, 1, MAXV, MAXV, MINV, 1), 0, zero_view);
		add_row(mk(K_TARGET, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, ONE, 0), 0, zero_view);
		add_row(mk(K_TARGET, MINV, MAXV, 0, MAXV, MINV, ONE, ONE, 0, MINV), 0, zero_view);
		// euler: zero angles, quarter and half turns, extremes, kind three
		add_row(mk(K_EULER, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, MAXV, MAXV, MAXV), 0,
			zero_view);
		add_row(mk(K_EULER, 0, 0, 0, 32'd102944, 32'd205887, -32'd102944, 0, 0, 0), 0,
			zero_view);
		add_row(mk(K_EULER, MAXV, MINV, MAXV, MAXV, MINV, MAXV, 0, 0, 0), 0, zero_view);
		add_row(mk(K_EULER, MINV, MAXV, MINV, MINV, MAXV, MINV, 0, 0, 0), 0, zero_view);
		add_row(mk(K_EULER3, ONE, -ONE, ONE, 32'd51472, -32'd51472, 32'd411775, 0, 0, 0),
			0, zero_view);
		add_row(mk(K_EULER3, 0, 0, 0, -32'd205887, 32'd1, -32'd1, MINV, 0, 0), 0,
			zero_view);

		sending = 1'b1;
		foreach (rows[i]) begin
			// typed rows are checked against the table as well
			if (rows[i].typed && view_of_pose(rows[i].p) !== rows[i].want) begin
				errors++;
				if (errors <= 10) $display("table row %0d disagrees with calculator", i);
			end
			send_pose(rows[i].p);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 800 && n < 1100);
			// hold off until the pipe has drained once
			if (n == 1500) begin
				pose.valid <= 1'b0;
				while (pending_views.size() != 0) @(negedge clk);
			end
			p = rnd_pose();
			send_pose(p);
		end
		pose.valid <= 1'b0;
		sending = 1'b0;

		while (pending_views.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);

		if (errors == 0)
			$display("** camera_view_matrix_builder_top: PASSED **");
		else
			$display("** camera_view_matrix_builder_top: FAILED **");
		$finish;
	end

endmodule
